/* src/decimal_digit_display_writer_top_defines.svh */
// ----------------------------------------------------------------------------
// decimal digit display writer assertion macros
// shared concurrent assertion forms for the port checker
// ----------------------------------------------------------------------------
`ifndef DECIMAL_DIGIT_DISPLAY_WRITER_TOP_DEFINES_SVH
`define DECIMAL_DIGIT_DISPLAY_WRITER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define DDW_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ddw port check failed");

// next-cycle implication, sampled on clk_i, off during reset
`define DDW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ddw port check failed");

`endif

/* src/ddw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddw_pkg
// types, codes and power-of-ten tables for the digit display writer
// ----------------------------------------------------------------------------
package ddw_pkg;

  localparam int unsigned VALUE_W   = 28;
  localparam int unsigned MAG_W     = 28;
  localparam int unsigned COUNT_W   = 4;
  localparam int unsigned ADDR_W    = 4;
  localparam int unsigned CODE_W    = 8;
  localparam int unsigned TAB_IDX_W = 3;
  // decimal place index, 0 to 8
  localparam int unsigned PLACE_W   = 4;
  localparam int unsigned DIGIT_W   = 4;
  // room for nine times the highest power of ten
  localparam int unsigned WIDE_W    = 32;

  localparam logic [CODE_W-1:0]  CODE_BLANK = 8'd15;
  localparam logic [CODE_W-1:0]  CODE_MINUS = 8'd10;
  // highest decimal place a magnitude up to 2^27 can use
  localparam logic [PLACE_W-1:0] TOP_PLACE  = 4'd8;

  localparam logic [WIDE_W-1:0] POW10 [9] = '{
    32'd1, 32'd10, 32'd100, 32'd1000, 32'd10000,
    32'd100000, 32'd1000000, 32'd10000000, 32'd100000000
  };

  typedef struct packed {
    logic [MAG_W-1:0]   mag;
    logic [COUNT_W-1:0] count;
    logic               neg;
  } cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_NEXT,
    S_DIV,
    S_EMIT
  } back_state_e;

endpackage

/* src/ddw_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddw_front
// takes input transactions, splits sign and magnitude, clamps the count
// ----------------------------------------------------------------------------
module ddw_front import ddw_pkg::*; #(
  parameter int unsigned DIGITS = 8
) (
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [VALUE_W-1:0] value_i,
  input  logic [COUNT_W-1:0]        digit_count_i,
  input  logic                      q_full_i,
  output logic                      q_push_o,
  output cmd_t                      q_cmd_o
);

  logic                 neg;
  logic [VALUE_W-1:0]   raw;

  assign raw        = value_i;
  assign neg        = raw[VALUE_W-1];
  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    q_cmd_o.neg   = neg;
    // two's complement negate, most negative value maps to 2^27 exactly
    q_cmd_o.mag   = neg ? MAG_W'(~raw + 1'b1) : MAG_W'(raw);
    q_cmd_o.count = (digit_count_i > COUNT_W'(DIGITS)) ? COUNT_W'(DIGITS) : digit_count_i;
  end

endmodule

/* src/ddw_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddw_queue
// two-entry command queue between front and back
// ----------------------------------------------------------------------------
module ddw_queue import ddw_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t pop_cmd_o
);

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = 1;

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]   fill_q, fill_d;
  logic            do_push, do_pop;

  assign full_o    = (fill_q == (PtrW+1)'(Depth));
  assign empty_o   = (fill_q == '0);
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && !empty_o;
  assign pop_cmd_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    fill_d   = fill_q;
    if (do_push && !do_pop) begin
      fill_d = fill_q + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

/* src/ddw_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddw_back
// write sequencer: blanks, minus, place-by-place digit extractor, output slot
// ----------------------------------------------------------------------------
module ddw_back import ddw_pkg::*; #(
  parameter int unsigned DIGITS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_empty_i,
  input  cmd_t              q_cmd_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ADDR_W-1:0] digit_address_o,
  output logic [CODE_W-1:0] digit_code_o,
  output logic              overflow_o,
  output logic              last_write_o
);

  back_state_e state_q, state_d;

  logic [MAG_W-1:0]     mag_q;
  logic [COUNT_W-1:0]   n_q;
  logic                 neg_q;
  logic [ADDR_W-1:0]    a_q;
  logic                 top_q;
  logic [PLACE_W-1:0]   place_q;
  logic [CODE_W-1:0]    q8_q;
  logic                 hi_q;
  logic [CODE_W-1:0]    code_pend_q;
  logic                 ovf_pend_q;

  logic                 out_valid_q;
  logic [ADDR_W-1:0]    out_addr_q;
  logic [CODE_W-1:0]    out_code_q;
  logic                 out_ovf_q;
  logic                 out_last_q;

  logic                 slot_free;
  logic                 is_blank, is_minus;
  logic                 do_pop, do_start, do_step, do_load;
  logic [TAB_IDX_W-1:0] pos_idx;
  logic [PLACE_W-1:0]   tgt_place;
  logic                 last_step;
  logic [WIDE_W-1:0]    pow_w;
  logic [WIDE_W-1:0]    mag_w;
  logic [WIDE_W-1:0]    sub_w;
  logic [DIGIT_W-1:0]   dig;
  logic [MAG_W-1:0]     mag_next;
  logic [CODE_W-1:0]    q8_next;
  logic                 hi_next;

  assign slot_free = !out_valid_q || out_ready_i;
  assign is_blank  = (a_q > ADDR_W'(n_q));
  assign is_minus  = neg_q && (a_q == ADDR_W'(n_q));
  assign pos_idx   = TAB_IDX_W'(a_q - 1'b1);
  assign tgt_place = PLACE_W'(pos_idx);
  assign last_step = (place_q == tgt_place);
  assign mag_w     = WIDE_W'(mag_q);

  // digit at the current decimal place, by compare against its multiples
  always_comb begin
    pow_w = POW10[place_q];
    dig   = '0;
    sub_w = '0;
    for (int m = 1; m < 10; m++) begin
      if (mag_w >= pow_w * WIDE_W'(m)) begin
        dig   = DIGIT_W'(m);
        sub_w = pow_w * WIDE_W'(m);
      end
    end
  end

  assign mag_next = MAG_W'(mag_w - sub_w);
  // low byte of the running quotient, times ten plus the new digit
  assign q8_next  = CODE_W'({q8_q, 3'b000}) + CODE_W'({q8_q, 1'b0}) + CODE_W'(dig);
  assign hi_next  = hi_q || (dig != '0);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (!q_empty_i) state_d = S_NEXT;
      end
      S_NEXT: begin
        state_d = (is_blank || is_minus) ? S_EMIT : S_DIV;
      end
      S_DIV: begin
        if (last_step) state_d = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) state_d = (a_q == ADDR_W'(1)) ? S_IDLE : S_NEXT;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    do_pop   = 1'b0;
    do_start = 1'b0;
    do_step  = 1'b0;
    do_load  = 1'b0;
    case (state_q)
      S_IDLE:  do_pop   = !q_empty_i;
      S_NEXT:  do_start = !(is_blank || is_minus);
      S_DIV:   do_step  = 1'b1;
      S_EMIT:  do_load  = slot_free;
      default: ;
    endcase
  end

  assign q_pop_o = do_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (do_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_pop) begin
      mag_q <= q_cmd_i.mag;
      n_q   <= q_cmd_i.count;
      neg_q <= q_cmd_i.neg;
      a_q   <= ADDR_W'(DIGITS);
      top_q <= 1'b1;
    end
    if (state_q == S_NEXT) begin
      if (is_blank) begin
        code_pend_q <= CODE_BLANK;
        ovf_pend_q  <= 1'b0;
      end else if (is_minus) begin
        code_pend_q <= CODE_MINUS;
        ovf_pend_q  <= 1'b0;
      end
    end
    if (do_start) begin
      // top digit walks every place above it, a lower digit only its own
      place_q <= top_q ? TOP_PLACE : tgt_place;
      q8_q    <= '0;
      hi_q    <= 1'b0;
    end
    if (do_step) begin
      // one decimal place per cycle, remainder stays in mag_q
      mag_q <= mag_next;
      q8_q  <= q8_next;
      hi_q  <= hi_next;
      if (last_step) begin
        code_pend_q <= q8_next;
        ovf_pend_q  <= top_q && hi_q;
        top_q       <= 1'b0;
      end else begin
        place_q <= place_q - 1'b1;
      end
    end
    if (do_load) begin
      out_addr_q <= a_q;
      out_code_q <= code_pend_q;
      out_ovf_q  <= ovf_pend_q;
      out_last_q <= (a_q == ADDR_W'(1));
      a_q        <= a_q - 1'b1;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign digit_address_o = out_addr_q;
  assign digit_code_o    = out_code_q;
  assign overflow_o      = out_ovf_q;
  assign last_write_o    = out_last_q;

endmodule

/* src/decimal_digit_display_writer_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_digit_display_writer_top
// turns a signed value and digit count into DIGITS code-B digit writes
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid_i/in_ready_o carry value_i (signed) and
//   digit_count_i; a count above DIGITS is treated as DIGITS
//   output channel: out_valid_o/out_ready_i carry one digit write per
//   transaction, DIGITS of them per input, highest address first, with
//   last_write_o high on the address 1 write
// sequencing
//   an input is held in the queue and popped in S_IDLE; S_NEXT then loads a
//   blank or minus, or S_DIV steps find the digit, and S_EMIT fills the
//   output slot; S_NEXT and S_EMIT run once per write, S_EMIT waiting while
//   the output slot is held; when any digit is shown, extraction takes one
//   step per decimal place from 10^8 down to the top digit, then one for each
//   lower digit; a new item is popped only once the address 1 write of the
//   previous item is loaded into the output slot
// reset
//   queue, sequencer and output slot come up empty, no write pending
// stalls
//   a stalled receiver holds the output slot; the sequencer waits with the
//   next write ready and the two-entry queue keeps taking input transactions
// ----------------------------------------------------------------------------
module decimal_digit_display_writer_top import ddw_pkg::*; #(
  parameter int unsigned DIGITS = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [VALUE_W-1:0] value_i,
  input  logic [COUNT_W-1:0]        digit_count_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [ADDR_W-1:0]         digit_address_o,
  output logic [CODE_W-1:0]         digit_code_o,
  output logic                      overflow_o,
  output logic                      last_write_o
);

  // front to queue
  logic q_push;
  logic q_full;
  cmd_t q_push_cmd;

  // queue to back
  logic q_pop;
  logic q_empty;
  cmd_t q_pop_cmd;

  // sign split and count clamp
  ddw_front #(
    .DIGITS (DIGITS)
  ) u_front (
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .value_i       (value_i),
    .digit_count_i (digit_count_i),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_cmd_o       (q_push_cmd)
  );

  // decouples the input side from the write sequencer
  ddw_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (q_push_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .empty_o    (q_empty),
    .pop_cmd_o  (q_pop_cmd)
  );

  // blanks, minus and digits, one write at a time
  ddw_back #(
    .DIGITS (DIGITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_empty_i       (q_empty),
    .q_cmd_i         (q_pop_cmd),
    .q_pop_o         (q_pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .digit_address_o (digit_address_o),
    .digit_code_o    (digit_code_o),
    .overflow_o      (overflow_o),
    .last_write_o    (last_write_o)
  );

endmodule

/* src/ddw_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddw_checker
// port-level checks on the input channel and the digit write stream, bound to the top level
// ----------------------------------------------------------------------------
`include "decimal_digit_display_writer_top_defines.svh"

module ddw_checker import ddw_pkg::*; #(
  parameter int unsigned DIGITS = 8
) (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic signed [VALUE_W-1:0] value_i,
  input logic [COUNT_W-1:0]        digit_count_i,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic [ADDR_W-1:0]         digit_address_o,
  input logic [CODE_W-1:0]         digit_code_o,
  input logic                      overflow_o,
  input logic                      last_write_o
);

  logic [ADDR_W-1:0] exp_addr_q;
  logic              out_acc;
  logic              in_wait;
  logic              out_wait;

  assign out_acc  = out_valid_o && out_ready_i;
  assign in_wait  = in_valid_i && !in_ready_o;
  assign out_wait = out_valid_o && !out_ready_i;

  // address each write should carry, counting down and wrapping per item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_addr_q <= ADDR_W'(DIGITS);
    end else if (out_acc) begin
      exp_addr_q <= last_write_o ? ADDR_W'(DIGITS) : exp_addr_q - 1'b1;
    end
  end

  `DDW_ASSERT_NEXT(a_in_hold, in_wait, in_valid_i && $stable(value_i) && $stable(digit_count_i))
  `DDW_ASSERT_NEXT(a_out_hold, out_wait, out_valid_o)
  `DDW_ASSERT_NEXT(a_out_stable, out_wait, $stable(digit_code_o) && $stable(overflow_o))
  `DDW_ASSERT_NOW(a_addr_order, out_valid_o, digit_address_o == exp_addr_q)
  `DDW_ASSERT_NOW(a_last_at_one, out_valid_o, last_write_o == (digit_address_o == ADDR_W'(1)))

endmodule

bind decimal_digit_display_writer_top ddw_checker #(
  .DIGITS (DIGITS)
) u_ddw_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .value_i         (value_i),
  .digit_count_i   (digit_count_i),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .digit_address_o (digit_address_o),
  .digit_code_o    (digit_code_o),
  .overflow_o      (overflow_o),
  .last_write_o    (last_write_o)
);
